// ===== src/ddwpd_pkg.sv =====
// shared types, constants and microcode table of the wheel speed controller
`default_nettype none

package ddwpd_pkg;

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SPD_W    = 17;
  localparam int unsigned DT_W     = 20;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CMD_W    = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // internal widths
  localparam int unsigned MUL_W    = 24;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned TGT_W    = 21;
  localparam int unsigned ERR_W    = TGT_W + 1;
  localparam int unsigned DE_W     = ERR_W + 1;
  localparam int unsigned HALF_W   = 20;
  localparam int unsigned WIDE_W   = 2 * HALF_W;
  localparam int unsigned ACC_W    = 62;
  localparam int unsigned REM_W    = ACC_W - 1;
  localparam int unsigned FRAC_SH  = 13;
  localparam int unsigned DIV_SH   = 24;
  localparam int unsigned DS_W     = DT_W + DIV_SH;
  localparam int unsigned Q_W      = 9;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned PC_W     = 6;

  // arithmetic constants
  localparam logic signed [MUL_W-1:0] K_TARGET_SCALE = 24'sd8192;
  localparam logic signed [MUL_W-1:0] K_TRIM_SCALE   = 24'sd256;
  localparam logic signed [MUL_W-1:0] K_US_PER_S     = 24'sd1000000;
  localparam logic [Q_W-1:0]          CMD_LIMIT      = 9'd300;
  localparam logic signed [CMD_W-1:0] CMD_MAX        = 10'sd300;
  localparam logic signed [CMD_W-1:0] CMD_MIN        = -10'sd300;

  // action codes
  localparam logic [ACT_W-1:0] ACT_DRIVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BAD   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TRIM  = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]        RST_TRACK_WIDTH = 16'd3610;
  localparam logic [GAIN_W-1:0]        RST_PROP_GAIN   = 16'd2048;
  localparam logic [GAIN_W-1:0]        RST_DERIV_GAIN  = 16'd38;
  localparam logic [GAIN_W-1:0]        RST_FF_GAIN     = 16'd2048;
  localparam logic signed [GAIN_W-1:0] RST_RIGHT_TRIM  = -16'sd512;

  typedef struct packed {
    logic [GAIN_W-1:0]        track_width;
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic [GAIN_W-1:0]        ff_gain;
    logic signed [GAIN_W-1:0] right_trim;
  } cfg_regs_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [SPD_W-1:0] lin_speed;
    logic signed [SPD_W-1:0] ang_rate;
    logic [DT_W-1:0]         dt_us;
    logic signed [SPD_W-1:0] meas_left;
    logic signed [SPD_W-1:0] meas_right;
  } drive_item_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MS_NONE,
    MS_TW_ANG,
    MS_LIN_K,
    MS_FF_TGT,
    MS_PG_ERR,
    MS_TRIM_K,
    MS_DG_DE,
    MS_ALO_DT,
    MS_AHI_DT,
    MS_XLO_US,
    MS_XHI_US
  } mul_sel_t;

  typedef enum logic [1:0] {
    AC_NONE,
    AC_LOAD,
    AC_LOADN,
    AC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    AX_NONE,
    AX_TGT_ERR,
    AX_DE,
    AX_SAVE_A,
    AX_SAVE_X,
    AX_ABS,
    AX_OVF,
    AX_DIV,
    AX_FIN,
    AX_CLR,
    AX_ZERO,
    AX_EMIT
  } aux_op_t;

  typedef enum logic [3:0] {
    JC_NEXT,
    JC_GOTO,
    JC_WAIT_IN,
    JC_WAIT_OUT,
    JC_IF_DTZ,
    JC_IF_CLR,
    JC_IF_STOP,
    JC_IF_BAD,
    JC_LOOP
  } jump_cond_t;

  typedef struct packed {
    mul_sel_t         mul_sel;
    acc_op_t          acc_op;
    logic             acc_sh;
    aux_op_t          aux;
    logic             wheel;
    jump_cond_t       jc;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic act_clear;
    logic act_stop;
    logic act_bad;
    logic dt_zero;
    logic loop_more;
  } seq_status_t;

  localparam logic WHEEL_L = 1'b0;
  localparam logic WHEEL_R = 1'b1;
  localparam logic SH_0    = 1'b0;
  localparam logic SH_HALF = 1'b1;

  // program addresses
  localparam logic [PC_W-1:0] A_IDLE  = 6'd0;
  localparam logic [PC_W-1:0] A_L_ABS = 6'd18;
  localparam logic [PC_W-1:0] A_L_DIV = 6'd20;
  localparam logic [PC_W-1:0] A_R_ABS = 6'd37;
  localparam logic [PC_W-1:0] A_R_DIV = 6'd39;
  localparam logic [PC_W-1:0] A_EMIT  = 6'd41;
  localparam logic [PC_W-1:0] A_CLR   = 6'd42;
  localparam logic [PC_W-1:0] A_STOP  = 6'd43;

  function automatic ctrl_word_t uw(input mul_sel_t m, input acc_op_t a, input logic sh,
                                    input aux_op_t x, input logic wh, input jump_cond_t j,
                                    input logic [PC_W-1:0] t);
    ctrl_word_t w;
    w.mul_sel = m;
    w.acc_op  = a;
    w.acc_sh  = sh;
    w.aux     = x;
    w.wheel   = wh;
    w.jc      = j;
    w.target  = t;
    return w;
  endfunction

  // control store; the product register is filled from the multiply select of the word before
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
    ctrl_word_t w;
    case (addr)
      // dispatch
      6'd0:  w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_WAIT_IN, A_IDLE);
      6'd1:  w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_IF_CLR,  A_CLR);
      6'd2:  w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_IF_STOP, A_STOP);
      6'd3:  w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_IF_BAD,  A_IDLE);
      // left wheel
      6'd4:  w = uw(MS_TW_ANG, AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd5:  w = uw(MS_LIN_K,  AC_LOADN, SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd6:  w = uw(MS_NONE,   AC_ADD,   SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd7:  w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_TGT_ERR, WHEEL_L, JC_NEXT,    A_IDLE);
      6'd8:  w = uw(MS_FF_TGT, AC_NONE,  SH_0,    AX_DE,      WHEEL_L, JC_NEXT,    A_IDLE);
      6'd9:  w = uw(MS_PG_ERR, AC_LOAD,  SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd10: w = uw(MS_NONE,   AC_ADD,   SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd11: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_SAVE_A,  WHEEL_L, JC_IF_DTZ,  A_L_ABS);
      6'd12: w = uw(MS_DG_DE,  AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd13: w = uw(MS_ALO_DT, AC_NONE,  SH_0,    AX_SAVE_X,  WHEEL_L, JC_NEXT,    A_IDLE);
      6'd14: w = uw(MS_AHI_DT, AC_LOAD,  SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd15: w = uw(MS_XLO_US, AC_ADD,   SH_HALF, AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd16: w = uw(MS_XHI_US, AC_ADD,   SH_0,    AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd17: w = uw(MS_NONE,   AC_ADD,   SH_HALF, AX_NONE,    WHEEL_L, JC_NEXT,    A_IDLE);
      6'd18: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_ABS,     WHEEL_L, JC_NEXT,    A_IDLE);
      6'd19: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_OVF,     WHEEL_L, JC_NEXT,    A_IDLE);
      6'd20: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_DIV,     WHEEL_L, JC_LOOP,    A_L_DIV);
      6'd21: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_FIN,     WHEEL_L, JC_NEXT,    A_IDLE);
      // right wheel, with trim
      6'd22: w = uw(MS_TW_ANG, AC_NONE,  SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd23: w = uw(MS_LIN_K,  AC_LOAD,  SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd24: w = uw(MS_NONE,   AC_ADD,   SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd25: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_TGT_ERR, WHEEL_R, JC_NEXT,    A_IDLE);
      6'd26: w = uw(MS_FF_TGT, AC_NONE,  SH_0,    AX_DE,      WHEEL_R, JC_NEXT,    A_IDLE);
      6'd27: w = uw(MS_PG_ERR, AC_LOAD,  SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd28: w = uw(MS_TRIM_K, AC_ADD,   SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd29: w = uw(MS_NONE,   AC_ADD,   SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd30: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_SAVE_A,  WHEEL_R, JC_IF_DTZ,  A_R_ABS);
      6'd31: w = uw(MS_DG_DE,  AC_NONE,  SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd32: w = uw(MS_ALO_DT, AC_NONE,  SH_0,    AX_SAVE_X,  WHEEL_R, JC_NEXT,    A_IDLE);
      6'd33: w = uw(MS_AHI_DT, AC_LOAD,  SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd34: w = uw(MS_XLO_US, AC_ADD,   SH_HALF, AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd35: w = uw(MS_XHI_US, AC_ADD,   SH_0,    AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd36: w = uw(MS_NONE,   AC_ADD,   SH_HALF, AX_NONE,    WHEEL_R, JC_NEXT,    A_IDLE);
      6'd37: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_ABS,     WHEEL_R, JC_NEXT,    A_IDLE);
      6'd38: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_OVF,     WHEEL_R, JC_NEXT,    A_IDLE);
      6'd39: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_DIV,     WHEEL_R, JC_LOOP,    A_R_DIV);
      6'd40: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_FIN,     WHEEL_R, JC_NEXT,    A_IDLE);
      // result, clear and stop
      6'd41: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_EMIT,    WHEEL_L, JC_WAIT_OUT, A_IDLE);
      6'd42: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_CLR,     WHEEL_L, JC_GOTO,    A_IDLE);
      6'd43: w = uw(MS_NONE,   AC_NONE,  SH_0,    AX_ZERO,    WHEEL_L, JC_GOTO,    A_EMIT);
      default: w = uw(MS_NONE, AC_NONE,  SH_0,    AX_NONE,    WHEEL_L, JC_GOTO,    A_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/diff_drive_wheel_pd_controller.sv =====
// top level of the two-wheel drive speed controller with feedforward and pd terms
`default_nettype none

// Two-wheel drive speed controller. A drive item (action 0) carries body speed,
// turn rate, the time step in microseconds and both measured wheel speeds; it
// yields one result with a left and a right motor command, each feedforward plus
// proportional plus derivative, clamped to +-300 and truncated toward zero; the
// right wheel adds a trim. A dt_us of zero drops the derivative term. A clear item
// (action 1) zeroes the stored wheel errors and yields no result, a stop item
// (action 2) yields a pair of zero commands, and action 3 is dropped. The work is
// run by a 44-word microprogram over one 24x24 multiplier and an accumulator; each
// wheel ends with a restoring divider that makes one quotient bit per cycle, nine
// bits in all. A new item is taken only when the program is back at its idle
// word, once the last item is through. The finished result sits in an output
// register, so the next item is taken while it waits; the block only stalls
// when a second result is ready before the first one was taken. Configuration
// writes are taken at any cycle and should only be made while the block is idle.

module diff_drive_wheel_pd_controller (
  input  wire                                       clk,
  input  wire                                       rst,
  // configuration
  input  wire                                       cfg_valid,
  output logic                                      cfg_ready,
  input  wire  [ddwpd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [ddwpd_pkg::GAIN_W-1:0]              cfg_data,
  // drive items
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire  [ddwpd_pkg::ACT_W-1:0]               action,
  input  wire  signed [ddwpd_pkg::SPD_W-1:0]        lin_speed,
  input  wire  signed [ddwpd_pkg::SPD_W-1:0]        ang_rate,
  input  wire  [ddwpd_pkg::DT_W-1:0]                dt_us,
  input  wire  signed [ddwpd_pkg::SPD_W-1:0]        meas_left,
  input  wire  signed [ddwpd_pkg::SPD_W-1:0]        meas_right,
  // motor commands
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output logic signed [ddwpd_pkg::CMD_W-1:0]        left_cmd,
  output logic signed [ddwpd_pkg::CMD_W-1:0]        right_cmd
);
  import ddwpd_pkg::*;

  cfg_regs_t               cfg;
  drive_item_t             item;
  ctrl_word_t              ctrl;
  seq_status_t             st;
  logic                    in_fire;
  logic                    out_free;
  logic                    loop_more;
  logic signed [CMD_W-1:0] cmd_left;
  logic signed [CMD_W-1:0] cmd_right;

  // config writes never stall
  assign cfg_ready = 1'b1;

  // input is taken only at the idle word of the program
  assign in_ready = (ctrl.jc == JC_WAIT_IN);
  assign in_fire  = in_valid && in_ready;
  // output register can take a new result this cycle
  assign out_free = !out_valid || out_ready;

  assign st.in_fire   = in_fire;
  assign st.out_free  = out_free;
  assign st.act_clear = (item.action == ACT_CLEAR);
  assign st.act_stop  = (item.action == ACT_STOP);
  assign st.act_bad   = (item.action == ACT_BAD);
  assign st.dt_zero   = (item.dt_us == '0);
  assign st.loop_more = loop_more;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_width <= RST_TRACK_WIDTH;
      cfg.prop_gain   <= RST_PROP_GAIN;
      cfg.deriv_gain  <= RST_DERIV_GAIN;
      cfg.ff_gain     <= RST_FF_GAIN;
      cfg.right_trim  <= RST_RIGHT_TRIM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRACK_WIDTH: cfg.track_width <= cfg_data;
        CFG_PROP_GAIN:   cfg.prop_gain   <= cfg_data;
        CFG_DERIV_GAIN:  cfg.deriv_gain  <= cfg_data;
        CFG_FF_GAIN:     cfg.ff_gain     <= cfg_data;
        CFG_RIGHT_TRIM:  cfg.right_trim  <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture on input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item.action <= ACT_DRIVE;
    end else if (in_fire) begin
      item.action <= action;
    end
    if (in_fire) begin
      item.lin_speed  <= lin_speed;
      item.ang_rate   <= ang_rate;
      item.dt_us      <= dt_us;
      item.meas_left  <= meas_left;
      item.meas_right <= meas_right;
    end
  end

  // output register; the emit word holds until this is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.aux == AX_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.aux == AX_EMIT && out_free) begin
      left_cmd  <= cmd_left;
      right_cmd <= cmd_right;
    end
  end

  ddwpd_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  ddwpd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .item      (item),
    .cmd_left  (cmd_left),
    .cmd_right (cmd_right),
    .loop_more (loop_more)
  );

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_cmd <= CMD_MAX && left_cmd >= CMD_MIN
                   && right_cmd <= CMD_MAX && right_cmd >= CMD_MIN))
    else $error("motor command outside the clamp range");

endmodule

`default_nettype wire

// ===== src/ddwpd_useq.sv =====
// microcode sequencer: step counter, control store and jump logic
`default_nettype none

module ddwpd_useq (
  input  wire                    clk,
  input  wire                    rst,
  input  ddwpd_pkg::seq_status_t st,
  output ddwpd_pkg::ctrl_word_t  ctrl
);
  import ddwpd_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [PC_W-1:0] pc_inc;

  assign ctrl   = ucode_rom(pc);
  assign pc_inc = pc + PC_W'(1);

  always_comb begin
    case (ctrl.jc)
      JC_NEXT:     pc_next = pc_inc;
      JC_GOTO:     pc_next = ctrl.target;
      JC_WAIT_IN:  pc_next = st.in_fire ? pc_inc : pc;
      JC_WAIT_OUT: pc_next = st.out_free ? ctrl.target : pc;
      JC_IF_DTZ:   pc_next = st.dt_zero ? ctrl.target : pc_inc;
      JC_IF_CLR:   pc_next = st.act_clear ? ctrl.target : pc_inc;
      JC_IF_STOP:  pc_next = st.act_stop ? ctrl.target : pc_inc;
      JC_IF_BAD:   pc_next = st.act_bad ? ctrl.target : pc_inc;
      JC_LOOP:     pc_next = st.loop_more ? ctrl.target : pc_inc;
      default:     pc_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ddwpd_dpath.sv =====
// datapath: shared multiplier, accumulator, error store and serial divider
`default_nettype none

module ddwpd_dpath (
  input  wire                                      clk,
  input  wire                                      rst,
  input  ddwpd_pkg::ctrl_word_t                    ctrl,
  input  ddwpd_pkg::cfg_regs_t                     cfg,
  input  ddwpd_pkg::drive_item_t                   item,
  output logic signed [ddwpd_pkg::CMD_W-1:0]       cmd_left,
  output logic signed [ddwpd_pkg::CMD_W-1:0]       cmd_right,
  output logic                                     loop_more
);
  import ddwpd_pkg::*;

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  p_term;
  logic signed [ACC_W-1:0]  acc_neg;
  logic signed [TGT_W-1:0]  tgt;
  logic signed [ERR_W-1:0]  err;
  logic signed [DE_W-1:0]   de;
  logic signed [ERR_W-1:0]  last_left;
  logic signed [ERR_W-1:0]  last_right;
  logic [WIDE_W-1:0]        areg;
  logic [WIDE_W-1:0]        xreg;
  logic [REM_W-1:0]         rem;
  logic [DS_W-1:0]          ds;
  logic [Q_W-1:0]           quo;
  logic [CNT_W-1:0]         cnt;
  logic                     neg;
  logic                     ovf;

  logic signed [TGT_W-1:0]  tgt_new;
  logic signed [SPD_W-1:0]  meas_sel;
  logic signed [ERR_W-1:0]  last_sel;
  logic [DT_W-1:0]          dt_eff;
  logic [REM_W-1:0]         ds_ext;
  logic [REM_W:0]           trial;
  logic [Q_W-1:0]           mag;
  logic signed [CMD_W-1:0]  cmd_val;

  // operand select
  always_comb begin
    case (ctrl.mul_sel)
      MS_TW_ANG: begin
        op_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.track_width};
        op_b = {{(MUL_W-SPD_W){item.ang_rate[SPD_W-1]}}, item.ang_rate};
      end
      MS_LIN_K: begin
        op_a = {{(MUL_W-SPD_W){item.lin_speed[SPD_W-1]}}, item.lin_speed};
        op_b = K_TARGET_SCALE;
      end
      MS_FF_TGT: begin
        op_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.ff_gain};
        op_b = {{(MUL_W-TGT_W){tgt[TGT_W-1]}}, tgt};
      end
      MS_PG_ERR: begin
        op_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.prop_gain};
        op_b = {{(MUL_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MS_TRIM_K: begin
        op_a = {{(MUL_W-GAIN_W){cfg.right_trim[GAIN_W-1]}}, cfg.right_trim};
        op_b = K_TRIM_SCALE;
      end
      MS_DG_DE: begin
        op_a = {{(MUL_W-GAIN_W){1'b0}}, cfg.deriv_gain};
        op_b = {{(MUL_W-DE_W){de[DE_W-1]}}, de};
      end
      MS_ALO_DT: begin
        op_a = {{(MUL_W-HALF_W){1'b0}}, areg[HALF_W-1:0]};
        op_b = {{(MUL_W-DT_W){1'b0}}, item.dt_us};
      end
      MS_AHI_DT: begin
        op_a = {{(MUL_W-HALF_W){areg[WIDE_W-1]}}, areg[WIDE_W-1:HALF_W]};
        op_b = {{(MUL_W-DT_W){1'b0}}, item.dt_us};
      end
      MS_XLO_US: begin
        op_a = {{(MUL_W-HALF_W){1'b0}}, xreg[HALF_W-1:0]};
        op_b = K_US_PER_S;
      end
      MS_XHI_US: begin
        op_a = {{(MUL_W-HALF_W){xreg[WIDE_W-1]}}, xreg[WIDE_W-1:HALF_W]};
        op_b = K_US_PER_S;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign p_term  = ctrl.acc_sh ? {prod[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}}
                               : {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc_neg = -acc;

  // floor of the scaled target is an arithmetic shift
  assign tgt_new  = acc[FRAC_SH+TGT_W-1:FRAC_SH];
  assign meas_sel = ctrl.wheel ? item.meas_right : item.meas_left;
  assign last_sel = ctrl.wheel ? last_right : last_left;
  assign dt_eff   = (item.dt_us == '0) ? DT_W'(1) : item.dt_us;
  assign ds_ext   = {{(REM_W-DS_W){1'b0}}, ds};
  assign trial    = {1'b0, rem} - {1'b0, ds_ext};
  assign mag      = (ovf || quo > CMD_LIMIT) ? CMD_LIMIT : quo;
  assign cmd_val  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign loop_more = (cnt != '0);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (ctrl.acc_op)
      AC_LOAD:  acc <= p_term;
      AC_LOADN: acc <= -p_term;
      AC_ADD:   acc <= acc + p_term;
      default:  acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
    end else begin
      case (ctrl.aux)
        AX_TGT_ERR: begin
          tgt <= tgt_new;
          err <= {tgt_new[TGT_W-1], tgt_new}
                 - {{(ERR_W-SPD_W){meas_sel[SPD_W-1]}}, meas_sel};
        end
        AX_DE: begin
          de <= {err[ERR_W-1], err} - {last_sel[ERR_W-1], last_sel};
          if (ctrl.wheel) begin
            last_right <= err;
          end else begin
            last_left <= err;
          end
        end
        AX_SAVE_A: areg <= acc[WIDE_W-1:0];
        AX_SAVE_X: xreg <= prod[WIDE_W-1:0];
        AX_ABS: begin
          neg <= acc[ACC_W-1];
          rem <= acc[ACC_W-1] ? acc_neg[REM_W-1:0] : acc[REM_W-1:0];
          ds  <= {dt_eff, {DIV_SH{1'b0}}};
        end
        AX_OVF: begin
          // quotient beyond the nine bits means the command clamps
          ovf <= rem >= {{(REM_W-DS_W-1){1'b0}}, ds, 1'b0};
          cnt <= CNT_W'(Q_W - 1);
          quo <= '0;
        end
        AX_DIV: begin
          if (!trial[REM_W]) begin
            rem <= trial[REM_W-1:0];
          end
          quo <= {quo[Q_W-2:0], !trial[REM_W]};
          ds  <= ds >> 1;
          cnt <= cnt - CNT_W'(1);
        end
        AX_FIN: begin
          if (ctrl.wheel) begin
            cmd_right <= cmd_val;
          end else begin
            cmd_left <= cmd_val;
          end
        end
        AX_CLR: begin
          last_left  <= '0;
          last_right <= '0;
        end
        AX_ZERO: begin
          cmd_left  <= '0;
          cmd_right <= '0;
        end
        default: ;
      endcase
    end
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.aux == AX_OVF |-> ds != '0)
    else $error("divisor is zero at the range check");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (ctrl.aux == AX_DIV && !ovf) |-> rem < {ds_ext[REM_W-2:0], 1'b0})
    else $error("division remainder out of bounds");

endmodule

`default_nettype wire
